### design/htir_pkg.sv
// Shared types and constants for the handle table reclaimer.
// No dependencies.
package htir_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CntW         = 11;
  localparam int unsigned WordW        = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC       = 3'd0,
    CMD_MARK_MOVED  = 3'd1,
    CMD_SET_OBJECT  = 3'd2,
    CMD_FLIP        = 3'd3,
    CMD_FINAL_SWEEP = 3'd4,
    CMD_READ        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_GC_OFF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SW_RD,
    S_SW_WR,
    S_POP_RD,
    S_POP_WR,
    S_MOD_RD,
    S_MOD_WR,
    S_FIN_RD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             free;
    logic             even;
    logic             odd;
    logic [WordW-1:0] word;
  } entry_t;

  typedef struct packed {
    logic [IdxW-1:0]  handle;
    logic [1:0]       status;
    logic             valid;
    logic [WordW-1:0] address;
    logic [CntW-1:0]  free_slots;
    logic             space;
  } result_t;

endpackage

### design/htir_mem.sv
// Entry store: one write port, one read port with registered read data.
// Uses htir_pkg.
module htir_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [htir_pkg::IdxW-1:0]     waddr_i,
  input  htir_pkg::entry_t              wdata_i,
  input  logic                          re_i,
  input  logic [htir_pkg::IdxW-1:0]     raddr_i,
  output htir_pkg::entry_t              rdata_o
);
  import htir_pkg::*;

  entry_t mem_q [TableEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/htir_ctrl.sv
// Command sequencer: read-modify-write over the entry store, sweep walk,
// free list head and counters. Uses htir_pkg and htir_mem.
module htir_ctrl #(
  parameter int unsigned RECLAIM_PER_ALLOC = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      gc_en_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                command_i,
  input  logic [htir_pkg::IdxW-1:0] handle_i,
  input  logic [31:0]               object_address_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output htir_pkg::result_t         res_o
);
  import htir_pkg::*;

  localparam int unsigned RW = $clog2(RECLAIM_PER_ALLOC + 1);
  localparam logic [CntW-1:0] NEnd = CntW'(TableEntries);

  state_e state_q, state_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [IdxW-1:0]  h_q, h_d, rh_q, rh_d, clr_q, clr_d;
  logic [WordW-1:0] addr_q, addr_d;
  logic [CntW-1:0]  scan_q, scan_d, sweep_q, sweep_d, head_q, head_d, count_q, count_d;
  logic [RW-1:0]    cnt_q, cnt_d;
  logic             space_q, space_d, ok_q, ok_d;
  logic [1:0]       status_q, status_d;

  logic             we, re;
  logic [IdxW-1:0]  waddr, raddr;
  entry_t           wdata, rd;

  logic             accept, dead, last_sweep;
  logic [CntW-1:0]  scan_nxt;
  logic [RW-1:0]    cnt_nxt;

  htir_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign scan_nxt = scan_q + 1'b1;
  assign cnt_nxt  = cnt_q + 1'b1;
  // final sweep frees entries lacking the current-parity mark
  assign dead = (cmd_q == CMD_FINAL_SWEEP) ? (space_q ? !rd.odd : !rd.even)
                                           : (!rd.even && !rd.odd);
  assign last_sweep = (scan_nxt == NEnd) ||
                      ((cmd_q == CMD_ALLOC) && (cnt_nxt == RW'(RECLAIM_PER_ALLOC)));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == IdxW'(TableEntries - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_ALLOC:       state_d = (sweep_q != NEnd) ? S_SW_RD : S_POP_RD;
            CMD_MARK_MOVED,
            CMD_SET_OBJECT:  state_d = S_MOD_RD;
            CMD_FLIP:        state_d = (gc_en_i && sweep_q != NEnd) ? S_SW_RD : S_FIN_RD;
            CMD_FINAL_SWEEP: state_d = (sweep_q != NEnd) ? S_SW_RD : S_FIN_RD;
            default:         state_d = S_FIN_RD;
          endcase
        end
      end
      S_SW_RD: state_d = S_SW_WR;
      S_SW_WR: begin
        if (!last_sweep)                state_d = S_SW_RD;
        else if (cmd_q == CMD_ALLOC)    state_d = S_POP_RD;
        else                            state_d = S_FIN_RD;
      end
      S_POP_RD: state_d = (count_q == '0 || head_q >= NEnd) ? S_RESP : S_POP_WR;
      S_POP_WR: state_d = rd.free ? S_FIN_RD : S_RESP;
      S_MOD_RD: state_d = S_MOD_WR;
      S_MOD_WR: state_d = S_FIN_RD;
      S_FIN_RD: state_d = S_RESP;
      S_RESP:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_d = cmd_q; h_d = h_q; rh_d = rh_q; clr_d = clr_q; addr_d = addr_q;
    scan_d = scan_q; sweep_d = sweep_q; head_d = head_q; count_d = count_q;
    cnt_d = cnt_q; space_d = space_q; ok_d = ok_q; status_d = status_q;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = '0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata.free = 1'b1;
        wdata.word = WordW'(clr_q) + 1'b1;
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d    = command_i;
          h_d      = handle_i;
          rh_d     = handle_i;
          addr_d   = object_address_i;
          scan_d   = sweep_q;
          cnt_d    = '0;
          ok_d     = 1'b1;
          status_d = STAT_OK;
          if (command_i == CMD_FLIP) begin
            if (!gc_en_i) begin
              status_d = STAT_GC_OFF;
            end else if (sweep_q == NEnd) begin
              space_d = !space_q;
              sweep_d = '0;
            end
          end
        end
      end
      S_SW_RD: begin
        re = 1'b1;
        raddr = scan_q[IdxW-1:0];
      end
      S_SW_WR: begin
        waddr = scan_q[IdxW-1:0];
        wdata = rd;
        if (!rd.free) begin
          we = 1'b1;
          if (dead) begin
            wdata.free = 1'b1;
            wdata.word = WordW'(head_q);
            head_d  = scan_q;
            count_d = count_q + 1'b1;
          end else if (space_q) begin
            wdata.even = 1'b0;
          end else begin
            wdata.odd = 1'b0;
          end
        end
        scan_d = scan_nxt;
        cnt_d  = cnt_nxt;
        if (last_sweep) begin
          if (cmd_q == CMD_ALLOC) begin
            sweep_d = scan_nxt;
          end else if (cmd_q == CMD_FLIP) begin
            space_d = !space_q;
            sweep_d = '0;
          end
        end
      end
      S_POP_RD: begin
        if (count_q == '0 || head_q >= NEnd) begin
          status_d = STAT_NO_SLOT;
          rh_d = '0;
          ok_d = 1'b0;
        end else begin
          re = 1'b1;
          raddr = head_q[IdxW-1:0];
        end
      end
      S_POP_WR: begin
        if (!rd.free) begin
          status_d = STAT_NO_SLOT;
          rh_d = '0;
          ok_d = 1'b0;
        end else begin
          we = 1'b1;
          waddr = head_q[IdxW-1:0];
          wdata.free = 1'b0;
          wdata.even = !space_q;
          wdata.odd  = space_q;
          wdata.word = addr_q;
          head_d  = (rd.word < WordW'(TableEntries)) ? CntW'(rd.word) : NEnd;
          count_d = count_q - 1'b1;
          rh_d    = head_q[IdxW-1:0];
        end
      end
      S_MOD_RD: begin
        re = 1'b1;
        raddr = h_q;
      end
      S_MOD_WR: begin
        waddr = h_q;
        wdata = rd;
        wdata.word = addr_q;
        if (cmd_q == CMD_MARK_MOVED) begin
          if (space_q) wdata.odd = 1'b1;
          else         wdata.even = 1'b1;
        end
        we = !rd.free;
      end
      S_FIN_RD: begin
        re = 1'b1;
        raddr = rh_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sweep_q <= '0;
      head_q  <= '0;
      count_q <= NEnd;
      space_q <= 1'b0;
      cnt_q   <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sweep_q <= sweep_d;
      head_q  <= head_d;
      count_q <= count_d;
      space_q <= space_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    h_q      <= h_d;
    rh_q     <= rh_d;
    addr_q   <= addr_d;
    ok_q     <= ok_d;
    status_q <= status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  always_comb begin
    res_o.handle     = rh_q;
    res_o.status     = status_q;
    res_o.valid      = ok_q && !rd.free && (rd.even || rd.odd);
    res_o.address    = ok_q ? rd.word : '0;
    res_o.free_slots = count_q;
    res_o.space      = space_q;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NEnd) else $error("free count out of range");
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q <= NEnd) else $error("sweep position out of range");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NEnd) else $error("free head out of range");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re)) else $error("store read and write in one cycle");
`endif

endmodule

### design/handle_table_incremental_reclaimer.sv
// Top level of the handle table with incremental reclaiming.
// Uses htir_pkg and htir_ctrl (which holds htir_mem).
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------------
//  in       | in_valid_i  | in_stall_o  | command_i, handle_i, object_address_i
//  out      | out_valid_o | out_stall_i | result_handle_o .. current_space_o
//  config   | gc_enabled_we_i (no stall) | gc_enabled_i
//
// One transaction in flight at a time in the sequencer.
// Alloc sweeps at most RECLAIM_PER_ALLOC entries, then pops the free list head.
// Flip and final sweep walk the remaining entries of the current sweep.
// After reset a clearing pass over every entry initializes the store, input stalled.
// One stalled result waits in the output register without blocking input; a second
// finished result waits in the sequencer and stalls the input.
module handle_table_incremental_reclaimer #(
  parameter int unsigned RECLAIM_PER_ALLOC = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gc_enabled_we_i,
  input  logic        gc_enabled_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [9:0]  handle_i,
  input  logic [31:0] object_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  result_handle_o,
  output logic [1:0]  status_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_address_o,
  output logic [10:0] free_slots_o,
  output logic        current_space_o
);
  import htir_pkg::*;

  logic    gc_en_q;
  logic    res_valid, res_ready, out_valid_q;
  result_t res, out_q;

  // collector enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gc_en_q <= 1'b0;
    else if (gc_enabled_we_i) gc_en_q <= gc_enabled_i;
  end

  htir_ctrl #(
    .RECLAIM_PER_ALLOC (RECLAIM_PER_ALLOC)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .gc_en_i          (gc_en_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .handle_i         (handle_i),
    .object_address_i (object_address_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_ready) out_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = out_q.handle;
  assign status_o        = out_q.status;
  assign entry_valid_o   = out_q.valid;
  assign entry_address_o = out_q.address;
  assign free_slots_o    = out_q.free_slots;
  assign current_space_o = out_q.space;

endmodule

### tb/htir_checker.sv
// Checker for the handle table reclaimer: watches both channels, keeps its own
// table state and compares every result. Depends on htir_pkg.
module htir_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        gc_enabled_we_i,
  input  logic        gc_enabled_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [9:0]  handle_i,
  input  logic [31:0] object_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [9:0]  result_handle_i,
  input  logic [1:0]  status_i,
  input  logic        entry_valid_i,
  input  logic [31:0] entry_address_i,
  input  logic [10:0] free_slots_i,
  input  logic        current_space_i,
  output int          errors_o,
  output int          pending_o
);
  import htir_pkg::*;

  logic [31:0] word_q [TableEntries];
  logic        free_q [TableEntries];
  logic        even_q [TableEntries];
  logic        odd_q  [TableEntries];
  int unsigned head_q, count_q, sweep_q;
  logic        space_q, gc_on_q;
  result_t     expected_results [$];

  task automatic push_free(int unsigned i);
    word_q[i] = head_q;
    free_q[i] = 1'b1;
    head_q    = i;
    count_q++;
  endtask

  task automatic sweep_one(int unsigned i);
    if (!free_q[i]) begin
      if (!even_q[i] && !odd_q[i]) push_free(i);
      else if (space_q) even_q[i] = 1'b0;
      else odd_q[i] = 1'b0;
    end
  endtask

  task automatic predict_result(logic [2:0] cmd, logic [9:0] h, logic [31:0] addr);
    result_t     r;
    int unsigned e, nxt;
    bit          ok;
    r.handle = h;
    r.status = STAT_OK;
    ok = (h < TableEntries);
    case (cmd)
      CMD_ALLOC: begin
        for (int k = 0; k < 4 && sweep_q < TableEntries; k++) begin
          sweep_one(sweep_q);
          sweep_q++;
        end
        if (count_q == 0 || head_q >= TableEntries || !free_q[head_q]) begin
          r.status = STAT_NO_SLOT;
          r.handle = '0;
          ok = 0;
        end else begin
          e   = head_q;
          nxt = word_q[e];
          head_q = (nxt < TableEntries) ? nxt : TableEntries;
          count_q--;
          word_q[e] = addr;
          free_q[e] = 1'b0;
          odd_q[e]  = space_q;
          even_q[e] = ~space_q;
          r.handle  = e[9:0];
          ok = 1;
        end
      end
      CMD_MARK_MOVED: begin
        if (ok && !free_q[h]) begin
          word_q[h] = addr;
          if (space_q) odd_q[h] = 1'b1;
          else even_q[h] = 1'b1;
        end
      end
      CMD_SET_OBJECT: begin
        if (ok && !free_q[h]) word_q[h] = addr;
      end
      CMD_FLIP: begin
        if (!gc_on_q) begin
          r.status = STAT_GC_OFF;
        end else begin
          for (int unsigned i = sweep_q; i < TableEntries; i++) sweep_one(i);
          space_q = ~space_q;
          sweep_q = 0;
        end
      end
      CMD_FINAL_SWEEP: begin
        for (int unsigned i = sweep_q; i < TableEntries; i++) begin
          if (!free_q[i]) begin
            if ((space_q && !odd_q[i]) || (!space_q && !even_q[i])) push_free(i);
            else if (space_q) even_q[i] = 1'b0;
            else odd_q[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (ok) begin
      r.valid   = !free_q[r.handle] && (even_q[r.handle] || odd_q[r.handle]);
      r.address = word_q[r.handle];
    end else begin
      r.valid   = 1'b0;
      r.address = '0;
    end
    r.free_slots = count_q[10:0];
    r.space      = space_q;
    expected_results.push_back(r);
  endtask

  task automatic compare_result();
    result_t x;
    if (expected_results.size() == 0) begin
      $error("result with no transaction outstanding");
      errors_o++;
      return;
    end
    x = expected_results.pop_front();
    if (result_handle_i !== x.handle) begin
      $error("result_handle exp %0d got %0d", x.handle, result_handle_i); errors_o++;
    end
    if (status_i !== x.status) begin
      $error("status exp %0d got %0d", x.status, status_i); errors_o++;
    end
    if (entry_valid_i !== x.valid) begin
      $error("entry_valid exp %0d got %0d", x.valid, entry_valid_i); errors_o++;
    end
    if (entry_address_i !== x.address) begin
      $error("entry_address exp %h got %h", x.address, entry_address_i); errors_o++;
    end
    if (free_slots_i !== x.free_slots) begin
      $error("free_slots exp %0d got %0d", x.free_slots, free_slots_i); errors_o++;
    end
    if (current_space_i !== x.space) begin
      $error("current_space exp %0d got %0d", x.space, current_space_i); errors_o++;
    end
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) begin
        word_q[i] = 32'(i + 1);
        free_q[i] = 1'b1;
        even_q[i] = 1'b0;
        odd_q[i]  = 1'b0;
      end
      head_q = 0; count_q = TableEntries; sweep_q = 0;
      space_q = 1'b0; gc_on_q = 1'b0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // results leave in acceptance order
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) predict_result(command_i, handle_i, object_address_i);
      if (gc_enabled_we_i) gc_on_q = gc_enabled_i;
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/tb_handle_table_incremental_reclaimer.sv
// Testbench top for the handle table reclaimer: stimulus, config phases, verdict.
// Depends on htir_pkg, htir_checker and the block itself.
module tb_handle_table_incremental_reclaimer;
  import htir_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        gc_enabled_we_i = 1'b0;
  logic        gc_enabled_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [9:0]  handle_i = '0;
  logic [31:0] object_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  result_handle_o;
  logic [1:0]  status_o;
  logic        entry_valid_o;
  logic [31:0] entry_address_o;
  logic [10:0] free_slots_o;
  logic        current_space_o;
  int          errors, pending;
  int unsigned cycle_count = 0;

  // idle controls
  bit          rx_idle_en = 1;     // random stall bursts on the result side
  bit          tx_idle_en = 1;     // random gaps on the command side
  bit          rx_hold = 0;        // long result-side hold-off

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  handle_table_incremental_reclaimer u_dut (
    .clk_i, .rst_ni, .gc_enabled_we_i, .gc_enabled_i,
    .in_valid_i, .in_stall_o, .command_i, .handle_i, .object_address_i,
    .out_valid_o, .out_stall_i, .result_handle_o, .status_o, .entry_valid_o,
    .entry_address_o, .free_slots_o, .current_space_o
  );

  htir_checker u_checker (
    .clk_i, .rst_ni, .gc_enabled_we_i, .gc_enabled_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .handle_i, .object_address_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_handle_i(result_handle_o),
    .status_i(status_o), .entry_valid_i(entry_valid_o),
    .entry_address_i(entry_address_o), .free_slots_i(free_slots_o),
    .current_space_i(current_space_o), .errors_o(errors), .pending_o(pending)
  );

  // Watchdog: room for every transaction being a full-table sweep under stalls.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 5000000) begin
      $display("tb_handle_table_incremental_reclaimer: FAIL");
      $finish;
    end
  end

  // Result-side stall: random stall bursts, or a long hold when asked.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) out_stall_i <= 1'b1;
      else if (rx_idle_en && $urandom_range(3) == 0) begin
        n = $urandom_range(6, 1);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else out_stall_i <= 1'b0;
    end
  end

  // Offer one command transaction and wait for its acceptance.
  task automatic send_cmd(logic [2:0] cmd, logic [9:0] h, logic [31:0] addr);
    if (tx_idle_en && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    handle_i         <= h;
    object_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Config write only when idle: every result is drained first, then pad.
  task automatic set_gc(logic v);
    drain();
    repeat (20) @(posedge clk_i);
    gc_enabled_we_i <= 1'b1;
    gc_enabled_i    <= v;
    @(posedge clk_i);
    gc_enabled_we_i <= 1'b0;
  endtask

  // Weighted random command: mostly allocs and marks, which drive the sweep.
  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_ALLOC;
    if (r < 60) return CMD_MARK_MOVED;
    if (r < 72) return CMD_SET_OBJECT;
    if (r < 77) return CMD_FLIP;
    if (r < 80) return CMD_FINAL_SWEEP;
    if (r < 96) return CMD_READ;
    return 3'($urandom_range(7, 6));   // unused codes behave as read
  endfunction

  // Handles mostly low so they hit allocated entries.
  function automatic logic [9:0] pick_handle();
    if ($urandom_range(3) != 0) return 10'($urandom_range(40));
    return 10'($urandom);
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) send_cmd(pick_cmd(), pick_handle(), $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: flip while off, extremes, every command, unknown codes.
    send_cmd(CMD_FLIP, 10'd0, 32'h0);
    send_cmd(CMD_READ, 10'd1023, 32'h0);
    send_cmd(CMD_SET_OBJECT, 10'd0, 32'hFFFF_FFFF);   // write to a free entry
    send_cmd(CMD_ALLOC, 10'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 10'd1023, 32'h0000_0000);
    send_cmd(CMD_ALLOC, 10'd0, 32'hA5A5_5A5A);
    send_cmd(CMD_MARK_MOVED, 10'd1, 32'h1234_5678);
    send_cmd(CMD_SET_OBJECT, 10'd2, 32'h8000_0001);
    send_cmd(CMD_READ, 10'd2, 32'h0);
    send_cmd(3'd6, 10'd0, 32'h0);
    send_cmd(3'd7, 10'd1023, 32'hFFFF_FFFF);
    send_cmd(CMD_FINAL_SWEEP, 10'd0, 32'h0);
    send_cmd(CMD_READ, 10'd0, 32'h0);
    set_gc(1'b1);
    send_cmd(CMD_ALLOC, 10'd0, 32'h5555_AAAA);
    send_cmd(CMD_FLIP, 10'd0, 32'h0);
    send_cmd(CMD_MARK_MOVED, 10'd0, 32'hCAFE_F00D);
    send_cmd(CMD_FLIP, 10'd0, 32'h0);
    send_cmd(CMD_FINAL_SWEEP, 10'd0, 32'h0);

    random_burst(120);

    // Sender pauses until every result has arrived.
    drain();

    // Receiver holds off while commands keep coming, so the block backs up.
    rx_hold = 1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        rx_hold = 0;
      end
      random_burst(6);
    join

    set_gc(1'b0);
    random_burst(80);

    // Run of allocs with no flips so the free list drains down.
    set_gc(1'b1);
    for (int i = 0; i < 200; i++) send_cmd(CMD_ALLOC, 10'($urandom), $urandom);
    send_cmd(CMD_ALLOC, 10'd0, 32'h0);
    send_cmd(CMD_FLIP, 10'd0, 32'h0);
    random_burst(100);

    // Last part with no idling at all.
    drain();
    rx_idle_en = 0;
    tx_idle_en = 0;
    random_burst(100);

    drain();
    repeat (2200) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("tb_handle_table_incremental_reclaimer: PASS");
    else $display("tb_handle_table_incremental_reclaimer: FAIL");
    $finish;
  end

endmodule
